@@ rtl/fir_filter_q15_saturating_defines.svh @@
// Assertion macros for the Q15 FIR filter checker.
// Included by the checker file only; needs clk and rst_n in scope.
`ifndef FIR_FILTER_Q15_SATURATING_DEFINES_SVH
`define FIR_FILTER_Q15_SATURATING_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FIR_Q15_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FIR_Q15_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fir_q15_pkg.sv @@
// Shared types and constants for the Q15 FIR filter.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package fir_q15_pkg;

    localparam int MAX_TAPS_DEFAULT = 64;
    localparam int SAMPLE_W         = 16;
    localparam int INDEX_W          = 6;
    localparam int TAP_COUNT_W      = 7;
    localparam int IN_TDATA_W       = 24;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 7'd63;

    localparam logic signed [31:0] ROUND_CONST = 32'sd16384;
    localparam logic signed [31:0] SAT_HIGH    = 32'sh3fffffff;
    localparam logic signed [31:0] SAT_LOW     = -32'sh40000000;

    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -16'sh8000;

    typedef enum logic
    {
        REG_TAP_COUNT = 1'b0,
        REG_NONE      = 1'b1
    } reg_index_t;

    typedef enum logic
    {
        OP_FILTER = 1'b0,
        OP_COEF   = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed
    {
        logic start_sample;
        logic write_coef;
        logic issue;
        logic load_out;
    } cmd_t;

    typedef struct packed
    {
        logic taps_zero;
        logic last_tap;
        logic pipe_busy;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/fir_q15_ctrl.sv @@
// Controller state machine for the Q15 FIR filter.
// Drives datapath commands from the input handshake and datapath status; uses fir_q15_pkg.
`default_nettype none

module fir_q15_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire fir_q15_pkg::op_t     op,
    output logic                      in_ready,
    input  wire fir_q15_pkg::status_t status,
    output fir_q15_pkg::cmd_t         cmd
);
    import fir_q15_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (op == OP_COEF)
                    begin
                        cmd.write_coef = 1'b1;
                    end
                    else
                    begin
                        cmd.start_sample = 1'b1;
                        state_next = status.taps_zero ? ST_DRAIN : ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                if (status.last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/fir_q15_datapath.sv @@
// Datapath of the Q15 FIR filter: sample ring buffer, coefficient memory,
// one multiply-accumulate pipeline and the output register. Uses fir_q15_pkg.
`default_nettype none

module fir_q15_datapath
#(
    parameter int MAX_TAPS = fir_q15_pkg::MAX_TAPS_DEFAULT
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire fir_q15_pkg::cmd_t                     cmd,
    output fir_q15_pkg::status_t                       status,
    input  wire logic [fir_q15_pkg::TAP_COUNT_W-1:0]   tap_count,
    input  wire logic signed [fir_q15_pkg::SAMPLE_W-1:0] value,
    input  wire logic [fir_q15_pkg::INDEX_W-1:0]       coef_index,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [fir_q15_pkg::SAMPLE_W-1:0]    filtered
);
    import fir_q15_pkg::*;

    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int PW    = 2 * SAMPLE_W;
    localparam int ACC_W = PW + CW + 1;

    localparam logic signed [ACC_W-1:0] ACC_ROUND = ACC_W'(ROUND_CONST);
    localparam logic signed [ACC_W-1:0] ACC_HIGH  = ACC_W'(SAT_HIGH);
    localparam logic signed [ACC_W-1:0] ACC_LOW   = ACC_W'(SAT_LOW);

    logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
    logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];

    logic [MAX_TAPS-1:0]        coef_valid_reg;
    logic [AW-1:0]              wp_reg;
    logic [AW-1:0]              k_reg;
    logic [CW-1:0]              fill_reg;
    logic signed [SAMPLE_W-1:0] hist_q_reg;
    logic signed [SAMPLE_W-1:0] coef_q_reg;
    logic                       s1_valid_reg;
    logic                       s1_use_reg;
    logic signed [PW-1:0]       prod_reg;
    logic                       s2_valid_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    logic [CW-1:0]              taps;
    logic [AW-1:0]              wp_inc;
    logic [AW:0]                wrap_sum;
    logic [AW-1:0]              hist_addr;
    logic [AW-1:0]              coef_addr;
    logic                       coef_hit;
    logic                       sample_known;
    logic signed [PW-1:0]       mult;
    logic signed [SAMPLE_W-1:0] sat_result;

    always_comb
    begin
        if (32'(tap_count) > MAX_TAPS)
        begin
            taps = CW'(MAX_TAPS);
        end
        else
        begin
            taps = CW'(tap_count);
        end
    end

    assign wp_inc    = (wp_reg == AW'(MAX_TAPS - 1)) ? '0 : wp_reg + 1'b1;
    assign wrap_sum  = {1'b0, wp_reg} + (AW + 1)'(MAX_TAPS) - {1'b0, k_reg};
    assign hist_addr = (wp_reg >= k_reg) ? (wp_reg - k_reg) : wrap_sum[AW-1:0];
    assign coef_addr = AW'(32'(coef_index));
    assign coef_hit  = 32'(coef_index) < MAX_TAPS;
    assign sample_known = CW'(k_reg) < fill_reg;
    assign mult = hist_q_reg * coef_q_reg;

    always_comb
    begin
        if (acc_reg > ACC_HIGH)
        begin
            sat_result = OUT_MAX;
        end
        else if (acc_reg < ACC_LOW)
        begin
            sat_result = OUT_MIN;
        end
        else
        begin
            sat_result = acc_reg[30:15];
        end
    end

    // The sample memory starts undefined; fill_reg masks entries never written.
    always_ff @(posedge clk)
    begin
        if (cmd.start_sample)
        begin
            hist_mem[wp_inc] <= value;
        end
        if (cmd.write_coef && coef_hit)
        begin
            coef_mem[coef_addr] <= value;
        end
        if (cmd.issue)
        begin
            hist_q_reg <= hist_mem[hist_addr];
            coef_q_reg <= coef_mem[k_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            prod_reg <= s1_use_reg ? mult : '0;
        end
        if (cmd.start_sample)
        begin
            acc_reg <= ACC_ROUND;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.load_out)
        begin
            out_data_reg <= sat_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_valid_reg <= '0;
            wp_reg         <= '0;
            k_reg          <= '0;
            fill_reg       <= '0;
            s1_valid_reg   <= 1'b0;
            s1_use_reg     <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.write_coef && coef_hit)
            begin
                coef_valid_reg[coef_addr] <= 1'b1;
            end
            if (cmd.start_sample)
            begin
                wp_reg <= wp_inc;
                k_reg  <= '0;
                if (fill_reg != CW'(MAX_TAPS))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            else if (cmd.issue)
            begin
                k_reg <= k_reg + 1'b1;
            end
            s1_valid_reg <= cmd.issue;
            s1_use_reg   <= cmd.issue && sample_known && coef_valid_reg[k_reg];
            s2_valid_reg <= s1_valid_reg;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.taps_zero = (taps == '0);
    assign status.last_tap  = (CW'(k_reg) == taps - 1'b1);
    assign status.pipe_busy = s1_valid_reg || s2_valid_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign filtered  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/fir_filter_q15_saturating.sv @@
// Q15 FIR filter top level: APB tap-count register, controller and datapath.
// A filter request holds the input through RUN, DRAIN and FINISH, RUN being skipped when
// T = min(tap_count, MAX_TAPS) is zero; the shared multiply-accumulate walks one tap per cycle.
// Its result is registered on leaving FINISH, which waits while the previous result is unaccepted.
// A coefficient request is taken while idle, keeps the input ready and gives no result.
// rst_n sets tap_count to 63, drops the output valid, and makes coefficients and history read zero.
`default_nettype none

module fir_filter_q15_saturating
#(
    parameter int MAX_TAPS = fir_q15_pkg::MAX_TAPS_DEFAULT
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [15:0] value, [21:16] coef_index, [23:22] zero
    input  wire logic [fir_q15_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [0] op
    input  wire logic [0:0]                            s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [15:0] filtered
    output logic [fir_q15_pkg::SAMPLE_W-1:0]           m_axis_tdata,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [fir_q15_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [fir_q15_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [fir_q15_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                       pready
);
    import fir_q15_pkg::*;

    logic [TAP_COUNT_W-1:0]     tap_count_reg;
    reg_index_t                 reg_sel;
    cmd_t                       cmd;
    status_t                    status;
    op_t                        op;
    logic signed [SAMPLE_W-1:0] value;
    logic [INDEX_W-1:0]         coef_index;
    logic signed [SAMPLE_W-1:0] filtered;

    assign reg_sel = reg_index_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_RESET;
        end
        else if (psel && penable && pwrite && (reg_sel == REG_TAP_COUNT))
        begin
            tap_count_reg <= pwdata[TAP_COUNT_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_TAP_COUNT: prdata = APB_DATA_W'(tap_count_reg);
            default:       prdata = '0;
        endcase
    end

    assign op         = op_t'(s_axis_tuser[0]);
    assign value      = s_axis_tdata[SAMPLE_W-1:0];
    assign coef_index = s_axis_tdata[SAMPLE_W+INDEX_W-1:SAMPLE_W];

    fir_q15_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .op       (op),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fir_q15_datapath #(
        .MAX_TAPS (MAX_TAPS)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .tap_count  (tap_count_reg),
        .value      (value),
        .coef_index (coef_index),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .filtered   (filtered)
    );

    assign m_axis_tdata = filtered;

endmodule

`default_nettype wire

@@ rtl/fir_q15_checker.sv @@
// Port-level checker for the Q15 FIR filter, bound to the top level.
// Uses fir_q15_pkg and the assertion macros of fir_filter_q15_saturating_defines.svh.
`default_nettype none
`include "fir_filter_q15_saturating_defines.svh"

module fir_q15_checker
(
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic [0:0]                         s_axis_tuser,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [fir_q15_pkg::SAMPLE_W-1:0]   m_axis_tdata
);
    import fir_q15_pkg::*;

    logic filter_req;
    logic coef_req;

    assign filter_req = s_axis_tvalid && s_axis_tready && (op_t'(s_axis_tuser[0]) == OP_FILTER);
    assign coef_req   = s_axis_tvalid && s_axis_tready && (op_t'(s_axis_tuser[0]) == OP_COEF);

    // A filter request occupies the block until its result is registered.
    `FIR_Q15_ASSERT_NEXT(a_filter_blocks_input, filter_req, !s_axis_tready, "ready after filter")

    // A coefficient write finishes in the cycle it is taken.
    `FIR_Q15_ASSERT_NEXT(a_coef_keeps_ready, coef_req, s_axis_tready, "stall after coef write")

    // A new result only appears at the end of a filter pass.
    `FIR_Q15_ASSERT_NOW(a_result_after_pass, $rose(m_axis_tvalid), $past(!s_axis_tready), "bad result")

    `FIR_Q15_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                         m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind fir_filter_q15_saturating fir_q15_checker u_checker (.*);

`default_nettype wire

@@ tb/fir_filter_q15_saturating_checker.sv @@
// Scoreboard for the Q15 FIR filter: watches both stream channels and the APB port,
// predicts each filtered sample and compares it with the block's output.
// Depends on fir_q15_pkg for the operation codes, register indexes and widths.
`default_nettype none

module fir_filter_q15_saturating_checker
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_tready,
    input  wire logic [fir_q15_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [0:0]                          s_tuser,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [fir_q15_pkg::SAMPLE_W-1:0]    m_tdata,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [fir_q15_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [fir_q15_pkg::APB_DATA_W-1:0]  pwdata,
    input  wire logic                                pready,
    output int                                       mismatches,
    output int                                       pending,
    output int                                       checked,
    output int                                       saturated
);
    import fir_q15_pkg::*;

    localparam int TAPS = MAX_TAPS_DEFAULT;
    localparam logic [APB_ADDR_W-1:0] TAP_COUNT_ADDR = APB_ADDR_W'(4 * int'(REG_TAP_COUNT));

    logic signed [SAMPLE_W-1:0] history [TAPS-1];
    logic signed [SAMPLE_W-1:0] coefs [TAPS];
    logic [TAP_COUNT_W-1:0]     tap_count;
    logic signed [SAMPLE_W-1:0] filtered_expected [$];

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] fir_output(input logic signed [SAMPLE_W-1:0] x,
                                                              output bit clipped);
        longint acc;
        longint shifted;
        int     taps;
        logic signed [SAMPLE_W-1:0] s;
        taps = (int'(tap_count) > TAPS) ? TAPS : int'(tap_count);
        acc = longint'(ROUND_CONST);
        for (int k = 0; k < taps; k++)
        begin
            s = (k == 0) ? x : history[k-1];
            acc += longint'(coefs[k]) * longint'(s);
        end
        clipped = 1'b0;
        if (acc > longint'(SAT_HIGH))
        begin
            acc = longint'(SAT_HIGH);
            clipped = 1'b1;
        end
        else if (acc < longint'(SAT_LOW))
        begin
            acc = longint'(SAT_LOW);
            clipped = 1'b1;
        end
        shifted = acc >>> 15;
        return shifted[SAMPLE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic signed [SAMPLE_W-1:0] value;
        logic [INDEX_W-1:0]         index;
        logic signed [SAMPLE_W-1:0] want;
        bit                         clipped;
        if (!rst_n)
        begin
            for (int k = 0; k < TAPS - 1; k++)
                history[k] = '0;
            for (int k = 0; k < TAPS; k++)
                coefs[k] = '0;
            tap_count = TAP_COUNT_RESET;
            filtered_expected.delete();
            mismatches = 0;
            pending = 0;
            checked = 0;
            saturated = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (filtered_expected.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d", $signed(m_tdata)));
                else
                begin
                    want = filtered_expected.pop_front();
                    checked++;
                    if (m_tdata !== want)
                        report_mismatch($sformatf("filtered %0d, expected %0d",
                                                  $signed(m_tdata), want));
                end
            end
            if (s_tvalid && s_tready)
            begin
                value = s_tdata[SAMPLE_W-1:0];
                index = s_tdata[SAMPLE_W +: INDEX_W];
                if (op_t'(s_tuser[0]) == OP_COEF)
                    coefs[index] = value;
                else
                begin
                    filtered_expected.push_back(fir_output(value, clipped));
                    if (clipped)
                        saturated++;
                    for (int k = TAPS - 2; k > 0; k--)
                        history[k] = history[k-1];
                    history[0] = value;
                end
            end
            if (psel && penable && pwrite && pready && paddr == TAP_COUNT_ADDR)
                tap_count = pwdata[TAP_COUNT_W-1:0];
            pending = filtered_expected.size();
        end
    end

endmodule

`default_nettype wire

@@ tb/fir_filter_q15_saturating_tb.sv @@
// Top of the Q15 FIR filter testbench: clock, reset, request stimulus, APB tap-count
// writes and output back-pressure; the checker module does prediction and comparison.
// Depends on fir_q15_pkg, fir_filter_q15_saturating and fir_filter_q15_saturating_checker.
`default_nettype none

module fir_filter_q15_saturating_tb;
    import fir_q15_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 80;
    localparam logic [APB_ADDR_W-1:0] TAP_COUNT_ADDR = APB_ADDR_W'(4 * int'(REG_TAP_COUNT));

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [SAMPLE_W-1:0]   m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int pending;
    int checked;
    int saturated;
    int src_idle;
    int rcv_stall;
    int hold_left;
    int cycles;
    int n_filter;
    int n_coef;

    fir_filter_q15_saturating u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    fir_filter_q15_saturating_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked),
        .saturated  (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
                $display("status: fail");
                $finish;
            end
        end
    end

    // The receiver: random stalls, or a long hold-off while hold_left counts down.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else
                m_tready = ($urandom_range(99) >= rcv_stall);
        end
    end

    task automatic send_request(input op_t op, input logic [SAMPLE_W-1:0] value,
                                input logic [INDEX_W-1:0] index);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {2'b00, index, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
        if (op == OP_COEF)
            n_coef++;
        else
            n_filter++;
    endtask

    task automatic random_request();
        logic [SAMPLE_W-1:0] value;
        case ($urandom_range(7))
            0:       value = 16'h7fff;
            1:       value = 16'h8000;
            2:       value = {$urandom_range(1) ? 16'hffff : 16'h0000};
            default: value = SAMPLE_W'($urandom);
        endcase
        if ($urandom_range(99) < 15)
            send_request(OP_COEF, value, INDEX_W'($urandom_range(63)));
        else
            send_request(OP_FILTER, value, INDEX_W'($urandom));
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_tap_count(input int taps);
        drain();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = TAP_COUNT_ADDR;
        pwdata  = APB_DATA_W'(taps);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic run_phase(input int taps, input int idle, input int stall, input int count);
        write_tap_count(taps);
        src_idle  = idle;
        rcv_stall = stall;
        repeat (count) random_request();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_FILTER;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        src_idle  = 0;
        rcv_stall = 0;
        hold_left = 0;
        n_filter  = 0;
        n_coef    = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // All coefficients zero after reset: the rounding constant alone gives zero.
        send_request(OP_FILTER, 16'h7fff, 6'd0);
        send_request(OP_FILTER, 16'h8000, 6'd63);
        send_request(OP_COEF, 16'h7fff, 6'd0);
        send_request(OP_COEF, 16'h8000, 6'd1);
        send_request(OP_COEF, 16'h7fff, 6'd62);
        send_request(OP_COEF, 16'h4000, 6'd63);
        send_request(OP_FILTER, 16'h0001, 6'd0);
        send_request(OP_FILTER, 16'hffff, 6'd0);
        send_request(OP_FILTER, 16'h0000, 6'd0);
        send_request(OP_FILTER, 16'h7fff, 6'd0);
        send_request(OP_FILTER, 16'h8000, 6'd0);
        // Most negative coefficient times most negative sample overflows Q30 upward.
        send_request(OP_COEF, 16'h8000, 6'd0);
        send_request(OP_FILTER, 16'h8000, 6'd0);
        // Two large negative products saturate downward.
        send_request(OP_FILTER, 16'h7fff, 6'd0);
        send_request(OP_FILTER, 16'h7fff, 6'd0);
        send_request(OP_COEF, 16'h1234, 6'd42);
        send_request(OP_FILTER, 16'h5a5a, 6'd21);
        send_request(OP_FILTER, 16'ha5a5, 6'd42);
        write_tap_count(63);
        send_request(OP_FILTER, 16'h0100, 6'd0);
        send_request(OP_FILTER, 16'hff00, 6'd0);

        // Full tap count, no idling, with a long output hold-off that backs up the input.
        run_phase(64, 0, 0, 50);
        @(posedge clk);
        hold_left = 400;
        @(negedge clk);
        repeat (50) random_request();

        run_phase(1, 60, 0, 50);
        drain();
        repeat (50) random_request();

        run_phase(127, 0, 60, 100);
        run_phase(0, 29, 29, 50);
        run_phase($urandom_range(2, 62), 29, 29, 50);
        run_phase(64, 0, 0, 25);

        drain();
        $display("sent %0d filter and %0d coefficient requests; %0d results checked, %0d saturated",
                 n_filter, n_coef, checked, saturated);
        $display("tap counts covered: 0, 1, 63, 64, 127 and one random value");
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
